/* hdl/ngr_pkg.sv */
// shared constants, types and sequencer states of the nearest grid resampler
package ngr_pkg;

  // grid geometry
  localparam int MAX_SIDE = 64;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int ADDR_W   = 2 * SIDE_W;
  localparam int DEPTH    = MAX_SIDE * MAX_SIDE;

  // word and register widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int APB_W  = 32;
  localparam int PADDR_W = 3;

  // register indexes (paddr bit 2 selects the register)
  localparam logic REG_SOURCE_SIDE = 1'b0;
  localparam logic REG_TARGET_SIDE = 1'b1;

  // operation codes of the input channel
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } ngr_op_t;

  // reset value of both side registers
  localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(MAX_SIDE);

  // divider: numerator (2t+1)*S, denominator 2T, two quotient bits a cycle
  localparam int NUM_W   = 2 * CFG_W;
  localparam int DEN_W   = CFG_W + 1;
  localparam int DIV_CYC = NUM_W / 2;
  localparam int CNT_W   = $clog2(DIV_CYC);

  // divider request and response
  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_READ
  } ngr_state_t;

endpackage

/* hdl/ngr_ram.sv */
// generic single write port, single read port ram with registered read
module ngr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/ngr_div.sv */
// shared restoring divider, two quotient bits per cycle
module ngr_div import ngr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;

  logic [DEN_W:0]   r1;
  logic [DEN_W:0]   r1_sub;
  logic             ge1;
  logic [DEN_W:0]   r2;
  logic [DEN_W:0]   r2_sub;
  logic             ge2;
  logic [DEN_W-1:0] rem_nxt;

  // two dependent subtract-and-compare steps
  always_comb begin
    r1      = {rem_r, num_r[NUM_W-1]};
    ge1     = (r1 >= {1'b0, den_r});
    r1_sub  = ge1 ? (r1 - {1'b0, den_r}) : r1;
    r2      = {r1_sub[DEN_W-1:0], num_r[NUM_W-2]};
    ge2     = (r2 >= {1'b0, den_r});
    r2_sub  = ge2 ? (r2 - {1'b0, den_r}) : r2;
    rem_nxt = r2_sub[DEN_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIV_CYC - 1);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      num_r <= req.numer;
      den_r <= req.denom;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[NUM_W-3:0], 2'b00};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-3:0], ge1, ge2};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* hdl/ngr_seq.sv */
// read sequencer: two index divisions through the shared divider, then a grid read
module ngr_seq import ngr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_go,
  input  logic [SIDE_W-1:0] row,
  input  logic [SIDE_W-1:0] col,
  input  logic [CFG_W-1:0]  s_eff,
  input  logic [CFG_W-1:0]  t_side,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [DATA_W-1:0] rd_data,
  output logic              busy,
  output logic              res_valid,
  output logic [DATA_W-1:0] res_value,
  output logic              res_oor
);

  ngr_state_t        state_r, state_nxt;
  logic [SIDE_W-1:0] row_r, col_r;
  logic [SIDE_W-1:0] sr_r, sr_nxt;
  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              oor_r, oor_nxt;

  logic              oor_in;
  logic [SIDE_W-1:0] quot_idx;
  logic [NUM_W-1:0]  prod_row;
  logic [NUM_W-1:0]  prod_col;

  // range check of the incoming target cell
  assign oor_in = ({1'b0, row} >= t_side) || ({1'b0, col} >= t_side);

  // numerators (2t+1)*S
  assign prod_row = NUM_W'({row_r, 1'b1}) * NUM_W'(s_eff);
  assign prod_col = NUM_W'({col_r, 1'b1}) * NUM_W'(s_eff);

  // clamp the quotient to the last source index
  always_comb begin
    if (div_rsp.quot >= NUM_W'(s_eff)) begin
      quot_idx = SIDE_W'(s_eff - 1'b1);
    end else begin
      quot_idx = div_rsp.quot[SIDE_W-1:0];
    end
  end

  // state register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go && state_r == ST_IDLE) begin
      row_r <= row;
      col_r <= col;
    end
    sr_r    <= sr_nxt;
    value_r <= value_nxt;
    oor_r   <= oor_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    sr_nxt        = sr_r;
    valid_nxt     = 1'b0;
    value_nxt     = value_r;
    oor_nxt       = oor_r;
    div_req.go    = 1'b0;
    div_req.numer = prod_row;
    div_req.denom = {t_side, 1'b0};
    rd_en         = 1'b0;
    rd_addr       = {sr_r, quot_idx};
    unique case (state_r)
      ST_IDLE: begin
        if (rd_go) begin
          if (oor_in || s_eff == '0) begin
            valid_nxt = 1'b1;
            value_nxt = '0;
            oor_nxt   = oor_in;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        div_req.go = 1'b1;
        state_nxt  = ST_DIV_ROW;
      end
      ST_DIV_ROW: begin
        if (div_rsp.done) begin
          sr_nxt        = quot_idx;
          div_req.go    = 1'b1;
          div_req.numer = prod_col;
          state_nxt     = ST_DIV_COL;
        end
      end
      ST_DIV_COL: begin
        if (div_rsp.done) begin
          rd_en     = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        valid_nxt = 1'b1;
        value_nxt = rd_data;
        oor_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = valid_r;
  assign res_value = value_r;
  assign res_oor   = oor_r;

endmodule

/* hdl/nearest_grid_resampler.sv */
// top level of the nearest-neighbour grid resampler
//
// Stores a square source grid of 32-bit words (up to 64 x 64) and answers
// reads of a target grid by nearest-neighbour sampling at cell centres.
// Input channel: an operation is transferred at a clock edge with start high
// and busy low. A write (in_operation 0) stores in_value at (in_row,
// in_column) in that same cycle and gives no result; busy stays low, so
// writes may follow back to back. Writes outside the source side are dropped.
// A read (in_operation 1) gives one result on out_value_res and
// out_out_of_range, marked by out_valid for exactly one cycle; the receiver
// cannot hold it off. A read outside the target side, or one with source side
// zero, answers zero in the cycle after the transfer. Any other read keeps
// busy high until its result is ready, so no new operation is taken before
// then: the sequencer launches the shared divider, which resolves the row
// index and then the column index at two quotient bits per cycle, then the
// grid memory is read through its registered port into the result register.
// Configuration: APB registers source_side (address 0) and target_side
// (address 4), both reset to 64; write them only while the block is idle.
// Reset (rst_n low, synchronous) returns the sequencer to idle; the grid
// contents are not cleared and must be written before they are read.
module nearest_grid_resampler import ngr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [SIDE_W-1:0]  in_row,
  input  logic [SIDE_W-1:0]  in_column,
  input  logic [DATA_W-1:0]  in_value,
  // result channel
  output logic               out_valid,
  output logic [DATA_W-1:0]  out_value_res,
  output logic               out_out_of_range,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  logic [CFG_W-1:0]  source_side_r;
  logic [CFG_W-1:0]  target_side_r;
  logic [CFG_W-1:0]  s_eff;
  logic              cfg_wr;
  logic              seq_busy;
  logic              accept;
  logic              wr_go;
  logic              rd_go;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_side_r <= SIDE_RESET;
      target_side_r <= SIDE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SOURCE_SIDE: source_side_r <= pwdata[CFG_W-1:0];
        REG_TARGET_SIDE: target_side_r <= pwdata[CFG_W-1:0];
        default:         source_side_r <= source_side_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_SIDE: prdata = {{(APB_W-CFG_W){1'b0}}, source_side_r};
      REG_TARGET_SIDE: prdata = {{(APB_W-CFG_W){1'b0}}, target_side_r};
      default:         prdata = '0;
    endcase
  end

  // effective source side saturates at the grid size
  assign s_eff = (source_side_r > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : source_side_r;

  // transfer decode
  assign busy   = seq_busy;
  assign accept = start && !seq_busy;
  assign wr_go  = accept && (in_operation == OP_WRITE)
                  && ({1'b0, in_row} < s_eff) && ({1'b0, in_column} < s_eff);
  assign rd_go  = accept && (in_operation == OP_READ);

  // source grid store
  ngr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_go),
    .wr_addr ({in_row, in_column}),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared index divider
  ngr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // read sequencer
  ngr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_go     (rd_go),
    .row       (in_row),
    .col       (in_column),
    .s_eff     (s_eff),
    .t_side    (target_side_r),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (seq_busy),
    .res_valid (out_valid),
    .res_value (out_value_res),
    .res_oor   (out_out_of_range)
  );

endmodule
